FILE: design/preprocessor_expression_alu_macros.svh
`ifndef PREPROCESSOR_EXPRESSION_ALU_MACROS_SVH
`define PREPROCESSOR_EXPRESSION_ALU_MACROS_SVH

// implication checked at every clock edge outside reset
`define PEA_ASSERT_IMP(label, ant, con, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ant) |-> (con)) \
      else $error(msg);

// condition that must never be seen outside reset
`define PEA_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

FILE: design/pea_pkg.sv
package pea_pkg;

   localparam int WIDTH   = 32;
   localparam int PORT_W  = 32;
   localparam int SHW     = $clog2(WIDTH);
   // input regs, decode stage, one stage per quotient bit, output reg
   localparam int LATENCY = WIDTH + 3;

   typedef enum logic [4:0] {
      OP_MUL  = 5'd0,
      OP_DIV  = 5'd1,
      OP_MOD  = 5'd2,
      OP_ADD  = 5'd3,
      OP_SUB  = 5'd4,
      OP_SHL  = 5'd5,
      OP_SHR  = 5'd6,
      OP_LT   = 5'd7,
      OP_LE   = 5'd8,
      OP_GT   = 5'd9,
      OP_GE   = 5'd10,
      OP_EQ   = 5'd11,
      OP_NE   = 5'd12,
      OP_AND  = 5'd13,
      OP_XOR  = 5'd14,
      OP_OR   = 5'd15,
      OP_LAND = 5'd16,
      OP_LOR  = 5'd17,
      OP_SEL  = 5'd18
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DIV0    = 2'd1,
      ST_MOD0    = 2'd2,
      ST_ILLEGAL = 2'd3
   } status_type;

   typedef struct packed {
      logic              valid;
      logic              use_q;
      logic              use_r;
      logic              neg;
      logic [WIDTH-1:0]  res;
      status_type        status;
   } tag_type;

   function automatic logic [WIDTH-1:0] to_w(input logic [PORT_W-1:0] x);
      return WIDTH'($signed(x));
   endfunction

endpackage

FILE: design/preprocessor_expression_alu.sv
// Preprocessor expression ALU: one binary or ternary #if operator per beat.
// Input: drive req_kind, req_lhs, req_rhs, req_alt with start high; the beat
//   is taken at any edge where busy is low. busy is high only during reset,
//   so a new beat can be taken every cycle.
// Output: rsp_valid strobes for one cycle with rsp_value and rsp_status.
//   The receiver cannot hold it off; there is nothing to stall.
// Pipeline: from the accepting edge to the edge that takes the result, every
//   operator passes two input/decode stages, one stage per quotient bit of the
//   pipelined divider and one output register.
//   All operators pass through the divider pipeline so results stay in order.
// Throughput: one beat per cycle outside reset.
// Reset: synchronous; clears all valid bits, so beats in flight are dropped.
module preprocessor_expression_alu (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [4:0]                  req_kind,
   input  logic [pea_pkg::PORT_W-1:0]  req_lhs,
   input  logic [pea_pkg::PORT_W-1:0]  req_rhs,
   input  logic [pea_pkg::PORT_W-1:0]  req_alt,
   output logic                        rsp_valid,
   output logic [pea_pkg::PORT_W-1:0]  rsp_value,
   output logic [1:0]                  rsp_status
);
   import pea_pkg::*;

   tag_type          front_tag, div_tag;
   logic [WIDTH-1:0] front_dvd, front_dsr, quo, rem;
   logic             valid_ff;
   logic [WIDTH-1:0] value_in, value_ff;
   status_type       status_ff;

   assign busy = reset;

   pea_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .kind     (req_kind),
      .lhs      (req_lhs),
      .rhs      (req_rhs),
      .alt      (req_alt),
      .tag      (front_tag),
      .dvd      (front_dvd),
      .dsr      (front_dsr)
   );

   pea_divider u_div (
      .clock (clock),
      .reset (reset),
      .tag_i (front_tag),
      .dvd_i (front_dvd),
      .dsr_i (front_dsr),
      .tag_o (div_tag),
      .quo_o (quo),
      .rem_o (rem)
   );

   always_comb begin
      if (div_tag.use_q) begin
         value_in = div_tag.neg ? -quo : quo;
      end else if (div_tag.use_r) begin
         value_in = div_tag.neg ? -rem : rem;
      end else begin
         value_in = div_tag.res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= div_tag.valid;
      end
      value_ff  <= value_in;
      status_ff <= div_tag.status;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_value  = PORT_W'($signed(value_ff));
   assign rsp_status = status_ff;

endmodule

FILE: design/pea_front.sv
module pea_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [4:0]                kind,
   input  logic [pea_pkg::PORT_W-1:0] lhs,
   input  logic [pea_pkg::PORT_W-1:0] rhs,
   input  logic [pea_pkg::PORT_W-1:0] alt,
   output pea_pkg::tag_type          tag,
   output logic [pea_pkg::WIDTH-1:0] dvd,
   output logic [pea_pkg::WIDTH-1:0] dsr
);
   import pea_pkg::*;

   logic             valid_a_ff;
   logic [4:0]       kind_a_ff;
   logic [WIDTH-1:0] a_ff, b_ff, c_ff;

   tag_type          tag_in, tag_ff;
   logic [WIDTH-1:0] dvd_in, dvd_ff, dsr_in, dsr_ff;

   logic [WIDTH-1:0] diff, prod;
   logic             a_neg, b_neg, lt, eq, b_in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
      kind_a_ff <= kind;
      a_ff      <= to_w(lhs);
      b_ff      <= to_w(rhs);
      c_ff      <= to_w(alt);
   end

   always_comb begin
      diff       = a_ff - b_ff;
      prod       = a_ff * b_ff;
      a_neg      = a_ff[WIDTH-1];
      b_neg      = b_ff[WIDTH-1];
      lt         = diff[WIDTH-1];
      eq         = (diff == '0);
      b_in_range = (b_ff[WIDTH-1:SHW] == '0);

      tag_in        = '0;
      tag_in.valid  = valid_a_ff;
      tag_in.status = ST_OK;
      dvd_in        = a_neg ? -a_ff : a_ff;
      dsr_in        = b_neg ? -b_ff : b_ff;

      unique case (kind_a_ff)
         OP_MUL:  tag_in.res = prod;
         OP_DIV: begin
            if (b_ff == '0) begin
               tag_in.res    = a_neg ? WIDTH'(1) : '1;
               tag_in.status = ST_DIV0;
            end else begin
               tag_in.use_q = 1'b1;
               tag_in.neg   = a_neg ^ b_neg;
            end
         end
         OP_MOD: begin
            if (b_ff == '0) begin
               tag_in.res    = a_ff;
               tag_in.status = ST_MOD0;
            end else begin
               tag_in.use_r = 1'b1;
               tag_in.neg   = a_neg;
            end
         end
         OP_ADD:  tag_in.res = a_ff + b_ff;
         OP_SUB:  tag_in.res = diff;
         OP_SHL:  tag_in.res = b_in_range ? (a_ff << b_ff[SHW-1:0]) : '0;
         OP_SHR:  tag_in.res = b_in_range ? WIDTH'($signed(a_ff) >>> b_ff[SHW-1:0])
                                          : {WIDTH{a_neg}};
         OP_LT:   tag_in.res = WIDTH'(lt);
         OP_LE:   tag_in.res = WIDTH'(lt | eq);
         OP_GT:   tag_in.res = WIDTH'(!lt && !eq);
         OP_GE:   tag_in.res = WIDTH'(!lt);
         OP_EQ:   tag_in.res = WIDTH'(eq);
         OP_NE:   tag_in.res = WIDTH'(!eq);
         OP_AND:  tag_in.res = a_ff & b_ff;
         OP_XOR:  tag_in.res = a_ff ^ b_ff;
         OP_OR:   tag_in.res = a_ff | b_ff;
         OP_LAND: tag_in.res = WIDTH'((a_ff != '0) && (b_ff != '0));
         OP_LOR:  tag_in.res = WIDTH'((a_ff != '0) || (b_ff != '0));
         OP_SEL:  tag_in.res = (a_ff != '0) ? b_ff : c_ff;
         default: tag_in.status = ST_ILLEGAL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign tag = tag_ff;
   assign dvd = dvd_ff;
   assign dsr = dsr_ff;

endmodule

FILE: design/pea_div_step.sv
module pea_div_step (
   input  logic                      clock,
   input  logic                      reset,
   input  pea_pkg::tag_type          tag_i,
   input  logic [pea_pkg::WIDTH-1:0] rem_i,
   input  logic [pea_pkg::WIDTH-1:0] dvd_i,
   input  logic [pea_pkg::WIDTH-1:0] dsr_i,
   output pea_pkg::tag_type          tag_o,
   output logic [pea_pkg::WIDTH-1:0] rem_o,
   output logic [pea_pkg::WIDTH-1:0] dvd_o,
   output logic [pea_pkg::WIDTH-1:0] dsr_o
);
   import pea_pkg::*;

   tag_type          tag_ff;
   logic [WIDTH-1:0] rem_in, rem_ff, dvd_in, dvd_ff, dsr_ff;
   logic [WIDTH:0]   shifted, trial;
   logic             qbit;

   // restoring step: quotient bits shift into the vacated dividend bits
   always_comb begin
      shifted = {rem_i, dvd_i[WIDTH-1]};
      trial   = shifted - {1'b0, dsr_i};
      qbit    = !trial[WIDTH];
      rem_in  = qbit ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
      dvd_in  = {dvd_i[WIDTH-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_i;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_i;
   end

   assign tag_o = tag_ff;
   assign rem_o = rem_ff;
   assign dvd_o = dvd_ff;
   assign dsr_o = dsr_ff;

endmodule

FILE: design/pea_divider.sv
module pea_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  pea_pkg::tag_type          tag_i,
   input  logic [pea_pkg::WIDTH-1:0] dvd_i,
   input  logic [pea_pkg::WIDTH-1:0] dsr_i,
   output pea_pkg::tag_type          tag_o,
   output logic [pea_pkg::WIDTH-1:0] quo_o,
   output logic [pea_pkg::WIDTH-1:0] rem_o
);
   import pea_pkg::*;

   tag_type          tag_s [WIDTH+1];
   logic [WIDTH-1:0] rem_s [WIDTH+1];
   logic [WIDTH-1:0] dvd_s [WIDTH+1];
   logic [WIDTH-1:0] dsr_s [WIDTH+1];

   assign tag_s[0] = tag_i;
   assign rem_s[0] = '0;
   assign dvd_s[0] = dvd_i;
   assign dsr_s[0] = dsr_i;

   for (genvar i = 0; i < WIDTH; i++) begin : g_step
      pea_div_step u_step (
         .clock (clock),
         .reset (reset),
         .tag_i (tag_s[i]),
         .rem_i (rem_s[i]),
         .dvd_i (dvd_s[i]),
         .dsr_i (dsr_s[i]),
         .tag_o (tag_s[i+1]),
         .rem_o (rem_s[i+1]),
         .dvd_o (dvd_s[i+1]),
         .dsr_o (dsr_s[i+1])
      );
   end

   assign tag_o = tag_s[WIDTH];
   assign quo_o = dvd_s[WIDTH];
   assign rem_o = rem_s[WIDTH];

endmodule

FILE: design/pea_checker.sv
`include "preprocessor_expression_alu_macros.svh"

module pea_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [4:0]                  req_kind,
   input logic [pea_pkg::PORT_W-1:0]  req_lhs,
   input logic [pea_pkg::PORT_W-1:0]  req_rhs,
   input logic [pea_pkg::PORT_W-1:0]  req_alt,
   input logic                        rsp_valid,
   input logic [pea_pkg::PORT_W-1:0]  rsp_value,
   input logic [1:0]                  rsp_status
);
   import pea_pkg::*;

   `PEA_ASSERT_IMP(a_fixed_latency, rsp_valid, $past(start && !busy, LATENCY), "response without request")
   `PEA_ASSERT_IMP(a_illegal_zero, rsp_valid && (rsp_status == ST_ILLEGAL), rsp_value == '0, "illegal op value not zero")
   `PEA_ASSERT_IMP(a_div0_value, rsp_valid && (rsp_status == ST_DIV0), (rsp_value == PORT_W'(1)) || (rsp_value == '1), "bad divide by zero value")
   `PEA_ASSERT_NEVER(a_never_busy, busy, "busy outside reset")

endmodule

bind preprocessor_expression_alu pea_checker u_pea_checker (.*);

FILE: test/tb_preprocessor_expression_alu.sv
`timescale 1ns / 100ps

module tb_preprocessor_expression_alu;
   import pea_pkg::*;

   localparam int RANDOM_BEATS = 2000;
   localparam int WATCHDOG_MAX = 2000;

   typedef struct {
      logic [4:0]  kind;
      logic [31:0] lhs;
      logic [31:0] rhs;
      logic [31:0] alt;
      bit          known;
      logic [31:0] value;
      status_type  status;
   } stim_row_type;

   typedef struct {
      logic [31:0] value;
      status_type  status;
   } alu_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [4:0]  req_kind = '0;
   logic [31:0] req_lhs = '0;
   logic [31:0] req_rhs = '0;
   logic [31:0] req_alt = '0;
   logic        rsp_valid;
   logic [31:0] rsp_value;
   logic [1:0]  rsp_status;

   alu_result_type pending_results[$];
   int          error_count = 0;
   int          beats_sent = 0;
   int          results_seen = 0;
   int          idle_cycles = 0;
   int          status_seen[4] = '{0, 0, 0, 0};

   preprocessor_expression_alu dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_lhs(req_lhs), .req_rhs(req_rhs), .req_alt(req_alt),
      .rsp_valid(rsp_valid), .rsp_value(rsp_value), .rsp_status(rsp_status)
   );

   always #1 clock = ~clock;

   // expression operator evaluated at WIDTH bits, result truncated to the port
   function automatic alu_result_type eval_operator(logic [4:0] kind, logic [31:0] lhs,
                                                    logic [31:0] rhs, logic [31:0] alt);
      logic signed [WIDTH-1:0] a, b, c, diff, res;
      logic [WIDTH-1:0]        ma, mb, q;
      status_type              st;
      alu_result_type          r;
      a = WIDTH'($signed(lhs));
      b = WIDTH'($signed(rhs));
      c = WIDTH'($signed(alt));
      diff = a - b;
      res = '0;
      st = ST_OK;
      ma = a[WIDTH-1] ? -a : a;
      mb = b[WIDTH-1] ? -b : b;
      case (kind)
         OP_MUL: res = a * b;
         OP_DIV: begin
            if (b == 0) begin
               res = a[WIDTH-1] ? 1 : -1;
               st = ST_DIV0;
            end else begin
               q = ma / mb;
               res = (a[WIDTH-1] != b[WIDTH-1]) ? -q : q;
            end
         end
         OP_MOD: begin
            if (b == 0) begin
               res = a;
               st = ST_MOD0;
            end else begin
               q = ma % mb;
               res = a[WIDTH-1] ? -q : q;
            end
         end
         OP_ADD: res = a + b;
         OP_SUB: res = diff;
         OP_SHL: res = (b < 0 || b >= WIDTH) ? '0 : a << b;
         OP_SHR: begin
            // kept apart from the fill so the shift stays arithmetic
            if (b < 0 || b >= WIDTH) res = a[WIDTH-1] ? '1 : '0;
            else res = a >>> b;
         end
         OP_LT:  res = diff[WIDTH-1];
         OP_LE:  res = diff[WIDTH-1] || diff == 0;
         OP_GT:  res = !diff[WIDTH-1] && diff != 0;
         OP_GE:  res = !diff[WIDTH-1];
         OP_EQ:  res = diff == 0;
         OP_NE:  res = diff != 0;
         OP_AND: res = a & b;
         OP_XOR: res = a ^ b;
         OP_OR:  res = a | b;
         OP_LAND: res = (a != 0) && (b != 0);
         OP_LOR:  res = (a != 0) || (b != 0);
         OP_SEL:  res = (a != 0) ? b : c;
         default: st = ST_ILLEGAL;
      endcase
      r.value = 32'(res);
      r.status = st;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
   endtask

   // send one beat; the table value, if given, must agree with the predictor too
   task automatic send_beat(stim_row_type row);
      alu_result_type exp_r;
      exp_r = eval_operator(row.kind, row.lhs, row.rhs, row.alt);
      if (row.known && (exp_r.value !== row.value || exp_r.status !== row.status))
         report_mismatch("table row vs predictor", exp_r.value, row.value);
      if (row.known) begin
         exp_r.value = row.value;
         exp_r.status = row.status;
      end
      start <= 1'b1;
      req_kind <= row.kind;
      req_lhs <= row.lhs;
      req_rhs <= row.rhs;
      req_alt <= row.alt;
      do @(posedge clock); while (busy);
      pending_results.push_back(exp_r);
      beats_sent++;
   endtask

   task automatic pause_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(int'($urandom_range(0, 40)) - 8);
         3: return 32'hffff_ffff;
         4: return 32'($urandom_range(0, 255));
         default: return $urandom;
      endcase
   endfunction

   // result side: strobes cannot be held off, compare each in order
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_value, 'x);
         end else begin
            alu_result_type exp_r;
            exp_r = pending_results.pop_front();
            if (rsp_value !== exp_r.value) report_mismatch("value", rsp_value, exp_r.value);
            if (rsp_status !== exp_r.status)
               report_mismatch("status", 32'(rsp_status), 32'(exp_r.status));
            status_seen[exp_r.status]++;
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("timeout with %0d results pending", pending_results.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      stim_row_type table_rows[$];
      stim_row_type row;
      int        idx;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      //                kind     lhs            rhs            alt          known value         status
      table_rows = '{
         '{OP_MUL,  32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 1'b1, 32'h0000_0001, ST_OK},
         '{OP_DIV,  32'h0000_0005, 32'h0000_0000, 32'h0, 1'b1, 32'hffff_ffff, ST_DIV0},
         '{OP_DIV,  32'hffff_fffb, 32'h0000_0000, 32'h0, 1'b1, 32'h0000_0001, ST_DIV0},
         '{OP_DIV,  32'h8000_0000, 32'hffff_ffff, 32'h0, 1'b1, 32'h8000_0000, ST_OK},
         '{OP_DIV,  32'hffff_fff9, 32'h0000_0002, 32'h0, 1'b1, 32'hffff_fffd, ST_OK},
         '{OP_MOD,  32'h8000_0000, 32'h0000_0000, 32'h0, 1'b1, 32'h8000_0000, ST_MOD0},
         '{OP_MOD,  32'h8000_0000, 32'hffff_ffff, 32'h0, 1'b1, 32'h0000_0000, ST_OK},
         '{OP_MOD,  32'hffff_fff9, 32'h0000_0002, 32'h0, 1'b1, 32'hffff_ffff, ST_OK},
         '{OP_ADD,  32'h7fff_ffff, 32'h0000_0001, 32'h0, 1'b1, 32'h8000_0000, ST_OK},
         '{OP_SUB,  32'h8000_0000, 32'h0000_0001, 32'h0, 1'b1, 32'h7fff_ffff, ST_OK},
         '{OP_SHL,  32'hffff_ffff, 32'h0000_001f, 32'h0, 1'b1, 32'h8000_0000, ST_OK},
         '{OP_SHL,  32'h0000_0001, 32'h0000_0020, 32'h0, 1'b1, 32'h0000_0000, ST_OK},
         '{OP_SHL,  32'h0000_0001, 32'hffff_ffff, 32'h0, 1'b1, 32'h0000_0000, ST_OK},
         '{OP_SHR,  32'h8000_0000, 32'h0000_001f, 32'h0, 1'b1, 32'hffff_ffff, ST_OK},
         '{OP_SHR,  32'h8000_0000, 32'h0000_0040, 32'h0, 1'b1, 32'hffff_ffff, ST_OK},
         '{OP_SHR,  32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b1, 32'h0000_0000, ST_OK},
         // wrapped difference: min < 1 reads as false
         '{OP_LT,   32'h8000_0000, 32'h0000_0001, 32'h0, 1'b1, 32'h0000_0000, ST_OK},
         '{OP_LE,   32'h0000_0003, 32'h0000_0003, 32'h0, 1'b1, 32'h0000_0001, ST_OK},
         '{OP_GT,   32'h7fff_ffff, 32'hffff_ffff, 32'h0, 1'b1, 32'h0000_0000, ST_OK},
         '{OP_GE,   32'h0000_0003, 32'h0000_0003, 32'h0, 1'b0, 32'h0, ST_OK},
         '{OP_EQ,   32'hffff_ffff, 32'hffff_ffff, 32'h0, 1'b0, 32'h0, ST_OK},
         '{OP_NE,   32'h0000_0000, 32'h8000_0000, 32'h0, 1'b0, 32'h0, ST_OK},
         '{OP_AND,  32'hf0f0_f0f0, 32'hffff_0000, 32'h0, 1'b0, 32'h0, ST_OK},
         '{OP_XOR,  32'haaaa_aaaa, 32'h5555_5555, 32'h0, 1'b1, 32'hffff_ffff, ST_OK},
         '{OP_OR,   32'h0000_0000, 32'h0000_0000, 32'h0, 1'b1, 32'h0000_0000, ST_OK},
         '{OP_LAND, 32'h8000_0000, 32'h0000_0000, 32'h0, 1'b1, 32'h0000_0000, ST_OK},
         '{OP_LOR,  32'h0000_0000, 32'h0000_0002, 32'h0, 1'b1, 32'h0000_0001, ST_OK},
         '{OP_SEL,  32'h0000_0000, 32'h1234_5678, 32'hffff_ffff, 1'b1, 32'hffff_ffff, ST_OK},
         '{OP_SEL,  32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b1, 32'h7fff_ffff, ST_OK},
         '{5'd31,   32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h0, ST_ILLEGAL}
      };
      foreach (table_rows[i]) send_beat(table_rows[i]);

      // hold off until the pipeline has drained
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);

      for (idx = 0; idx < RANDOM_BEATS; idx++) begin
         row.kind = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(19, 31))
                                                  : 5'($urandom_range(0, 18));
         row.lhs = pick_operand();
         row.rhs = ($urandom_range(0, 9) == 0) ? 32'h0 : pick_operand();
         row.alt = $urandom;
         row.known = 1'b0;
         row.value = '0;
         row.status = ST_OK;
         send_beat(row);
         if (idx < RANDOM_BEATS - 300 && $urandom_range(0, 5) == 0)
            pause_sender($urandom_range(1, 9));
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      $display("sent %0d beats over all 19 operators and illegal codes;", beats_sent);
      $display("checked %0d results: %0d div-by-zero, %0d mod-by-zero, %0d illegal",
               results_seen, status_seen[ST_DIV0], status_seen[ST_MOD0],
               status_seen[ST_ILLEGAL]);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
